// ===== rtl/rsa_pkg.sv =====
// Package for the ring staging allocator: widths, codes, storage geometry
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package rsa_pkg;

  // Region FIFO geometry.
  localparam int MAX_REGIONS = 64;
  localparam int OFFSET_BITS = 24;
  localparam int SLOT_W      = $clog2(MAX_REGIONS);
  localparam int COUNT_W     = $clog2(MAX_REGIONS + 1);

  // Field widths fixed by the item format.
  localparam int OP_W     = 1;
  localparam int BYTES_W  = 25;
  localparam int TAG_W    = 48;
  localparam int ALIGN_W  = 4;
  localparam int STATUS_W = 3;
  localparam int LIVE_W   = 7;
  localparam int OFS_W    = 24;

  // Head arithmetic: end of a region plus the largest alignment mask.
  localparam int HEAD_W = BYTES_W + 1;
  localparam int SUM_W  = HEAD_W + 1;

  // Stream packing.
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 32;

  // Memory entry: start offset in the low bits, completion tag above it.
  localparam int ENTRY_W = OFFSET_BITS + TAG_W;

  // Reset values of the configuration registers.
  localparam logic [BYTES_W-1:0] RING_BYTES_RST = BYTES_W'(16777216);
  localparam logic [ALIGN_W-1:0] ALIGN_RST      = ALIGN_W'(4);
  localparam logic [BYTES_W-1:0] CAP_MAX        = BYTES_W'(1) << OFFSET_BITS;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 1'b0,
    OP_RETIRE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_FULL      = 3'd3,
    ST_RETIRED   = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CFG_RING_BYTES = 1'b0,
    CFG_ALIGN_LOG2 = 1'b1
  } cfg_index_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic alloc_commit;
    logic pop;
    logic retire_done;
  } rsa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic pop_ok;
  } rsa_stat_t;

endpackage

// ===== rtl/rsa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rsa_ctrl.sv =====
// Controller of the ring staging allocator: sequences allocate and retire items.
// Depends on rsa_pkg.
module rsa_ctrl
  import rsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  input  rsa_stat_t stat,
  output rsa_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_ALLOC  = 3'b010,
    S_RETIRE = 3'b100
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (op_t'(in_op) == OP_RETIRE) ? S_RETIRE : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (stat.out_free) begin
          cmd.alloc_commit = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_RETIRE: begin
        // One front region leaves per cycle until the FIFO is empty or the oldest tag is too new.
        if (stat.pop_ok) begin
          cmd.pop = 1'b1;
        end else if (stat.out_free) begin
          cmd.retire_done = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/rsa_datapath.sv =====
// Datapath of the ring staging allocator: configuration, FIFO pointers, placement
// arithmetic, region memory and the result register. Depends on rsa_pkg, rsa_ram.
module rsa_datapath
  import rsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  rsa_cmd_t            cmd,
  output rsa_stat_t           stat,
  input  logic [BYTES_W-1:0]  req_bytes,
  input  logic [TAG_W-1:0]    req_tag,
  input  logic [TAG_W-1:0]    req_done,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_sel,
  input  logic [BYTES_W-1:0]  cfg_wdata,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [STATUS_W-1:0] res_status,
  output logic [OFS_W-1:0]    res_offset,
  output logic [LIVE_W-1:0]   res_live
);

  logic [BYTES_W-1:0]     ring_bytes;
  logic [ALIGN_W-1:0]     align_log2;
  logic [BYTES_W-1:0]     size_q;
  logic [TAG_W-1:0]       tag_q;
  logic [TAG_W-1:0]       done_q;
  logic [SLOT_W-1:0]      oldest_slot, oldest_slot_next;
  logic [SLOT_W-1:0]      newest_slot;
  logic [COUNT_W-1:0]     live_count;
  logic [OFFSET_BITS-1:0] newest_start;
  logic [BYTES_W-1:0]     newest_end;

  logic [ENTRY_W-1:0]     rd_entry;
  logic [OFFSET_BITS-1:0] o_start;
  logic [TAG_W-1:0]       o_tag;

  logic [BYTES_W-1:0]     cap;
  logic [HEAD_W-1:0]      amask;
  logic [HEAD_W-1:0]      head;
  logic [SUM_W-1:0]       head_sum;
  logic                   wrapped, fits_head, fits_zero, granted;
  logic [OFFSET_BITS-1:0] at;
  logic [SLOT_W-1:0]      slot;
  status_t                alloc_status;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(MAX_REGIONS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_bytes <= RING_BYTES_RST;
      align_log2 <= ALIGN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_sel))
        CFG_RING_BYTES: ring_bytes <= cfg_wdata;
        CFG_ALIGN_LOG2: align_log2 <= cfg_wdata[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture; a zero-byte request is taken as one byte.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      size_q <= (req_bytes == '0) ? BYTES_W'(1) : req_bytes;
      tag_q  <= req_tag;
      done_q <= req_done;
    end
  end

  // The memory is read at the oldest slot it will hold next cycle, so the
  // registered read always shows the current front region.
  assign oldest_slot_next = (cmd.pop && live_count != COUNT_W'(1)) ?
                            next_slot(oldest_slot) : oldest_slot;

  rsa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_REGIONS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.alloc_commit && granted),
    .waddr(slot),
    .wdata({tag_q, at}),
    .raddr(oldest_slot_next),
    .rdata(rd_entry)
  );

  assign o_start = rd_entry[OFFSET_BITS-1:0];
  assign o_tag   = rd_entry[ENTRY_W-1:OFFSET_BITS];

  // Placement.
  always_comb begin
    cap       = (ring_bytes > CAP_MAX) ? CAP_MAX : ring_bytes;
    amask     = ~({HEAD_W{1'b1}} << align_log2);
    head      = (HEAD_W'(newest_end) + amask) & ~amask;
    head_sum  = SUM_W'(head) + SUM_W'(size_q);
    wrapped   = o_start > newest_start;
    fits_head = wrapped ? (head_sum <= SUM_W'(o_start)) : (head_sum <= SUM_W'(cap));
    fits_zero = !wrapped && (size_q <= BYTES_W'(o_start));
    granted   = 1'b0;
    at        = '0;
    if (size_q > cap) begin
      alloc_status = ST_TOO_LARGE;
    end else if (live_count >= COUNT_W'(MAX_REGIONS)) begin
      alloc_status = ST_FULL;
    end else if (live_count == '0) begin
      alloc_status = ST_GRANTED;
      granted      = 1'b1;
    end else if (fits_head) begin
      alloc_status = ST_GRANTED;
      granted      = 1'b1;
      at           = head[OFFSET_BITS-1:0];
    end else if (fits_zero) begin
      alloc_status = ST_GRANTED;
      granted      = 1'b1;
    end else begin
      alloc_status = ST_NO_SPACE;
    end
    slot = (live_count == '0) ? oldest_slot : next_slot(newest_slot);
  end

  // FIFO pointers and the cached newest region.
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_slot <= '0;
      newest_slot <= '0;
      live_count  <= '0;
    end else if (cmd.alloc_commit && granted) begin
      newest_slot <= slot;
      live_count  <= live_count + COUNT_W'(1);
    end else if (cmd.pop) begin
      live_count  <= live_count - COUNT_W'(1);
      oldest_slot <= oldest_slot_next;
      if (live_count == COUNT_W'(1)) begin
        newest_slot <= oldest_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_commit && granted) begin
      newest_start <= at;
      newest_end   <= BYTES_W'(at) + size_q;
    end
  end

  assign stat.pop_ok   = (live_count != '0) && (o_tag <= done_q);
  assign stat.out_free = !res_valid || res_ready;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.alloc_commit || cmd.retire_done) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_commit) begin
      res_status <= alloc_status;
      res_offset <= OFS_W'(at);
      res_live   <= LIVE_W'(granted ? live_count + COUNT_W'(1) : live_count);
    end else if (cmd.retire_done) begin
      res_status <= ST_RETIRED;
      res_offset <= '0;
      res_live   <= LIVE_W'(live_count);
    end
  end

endmodule

// ===== rtl/ring_staging_allocator_top.sv =====
// Top level of the ring staging allocator: stream ports, configuration port,
// controller and datapath. Depends on rsa_pkg, rsa_ctrl, rsa_datapath, rsa_ram.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser operation, tdata request
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser status, tdata offset, count
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// An allocate item is accepted, then placed when the output register is free;
// placement reads the oldest region from the region memory and the newest
// region from registers. A retire item pops completed regions from the front,
// bounded by the single read port of the region memory. A finished result sits
// in the output register, and the next item is accepted while it waits; only a
// second result stalls behind it. Reset is synchronous, clears the FIFO
// pointers, the region count and the output valid, and restores the ring size
// and alignment defaults; no clearing pass is needed.
module ring_staging_allocator_top
  import rsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [24:0] request_bytes, [72:25] region_tag, [120:73] completed_tag, rest zero.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] operation.
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [23:0] region_offset, [30:24] live_regions, [31] zero.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [2:0] status.
  output logic [STATUS_W-1:0]   m_axis_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [BYTES_W-1:0]    cfg_data
);

  rsa_cmd_t            cmd;
  rsa_stat_t           stat;
  logic                in_ready;
  logic [OFS_W-1:0]    res_offset;
  logic [LIVE_W-1:0]   res_live;

  // Configuration is always taken; the user must write it only while idle (not enforced).
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = in_ready;

  rsa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_op   (s_axis_tuser[0]),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rsa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_bytes (s_axis_tdata[BYTES_W-1:0]),
    .req_tag   (s_axis_tdata[BYTES_W+TAG_W-1:BYTES_W]),
    .req_done  (s_axis_tdata[BYTES_W+2*TAG_W-1:BYTES_W+TAG_W]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_index),
    .cfg_wdata (cfg_data),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res_status(m_axis_tuser),
    .res_offset(res_offset),
    .res_live  (res_live)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - OFS_W - LIVE_W){1'b0}}, res_live, res_offset};

endmodule

// ===== rtl/rsa_checker.sv =====
// Port-level checker for the ring staging allocator, bound to the top level.
// Depends on rsa_pkg.
module rsa_checker
  import rsa_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]   m_axis_tuser
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only a granted result carries an offset.
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_GRANTED |-> m_axis_tdata[OFS_W-1:0] == '0)
    else $error("offset on a refused or retire result");

  // A grant leaves at least one live region and never more than the FIFO holds.
  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_GRANTED |->
      m_axis_tdata[OFS_W+LIVE_W-1:OFS_W] != '0 &&
      m_axis_tdata[OFS_W+LIVE_W-1:OFS_W] <= LIVE_W'(MAX_REGIONS))
    else $error("bad live count on grant");

  // After an accept the block is busy, so input is never accepted back to back.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on back-to-back cycles");

endmodule

bind ring_staging_allocator_top rsa_checker u_rsa_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ===== bench/ring_staging_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ring_staging_allocator_top: directed and random allocate and
// retire items, checked against an in-bench model of the region ring. Needs rsa_pkg and the RTL.
module ring_staging_allocator_top_tb
  import rsa_pkg::*;
();

  // The run ends as failed after this many cycles in which no channel moves an item.
  localparam int QUIET_LIMIT = 5000;
  // Cycles left to run after the last result, so a stray extra result still shows up.
  localparam int SETTLE_CYCLES = 20;
  // Room for expected results that are accepted but not yet returned.
  localparam int WANT_DEPTH = 16;
  localparam logic [BYTES_W-1:0] BYTES_ALL = '1;
  localparam logic [TAG_W-1:0]   TAG_MAX   = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = OP_ALLOC;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index = CFG_RING_BYTES;
  logic [BYTES_W-1:0]    cfg_data = '0;

  ring_staging_allocator_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One expected result: what the block must report for one accepted item.
  typedef struct {
    status_t            status;
    logic [OFS_W-1:0]   offset;
    logic [LIVE_W-1:0]  live;
  } ring_outcome_t;

  // Expected results in acceptance order, a small ring indexed by running counts.
  // The sender advances want_wr and the checker advances want_rd.
  ring_outcome_t want_fifo [WANT_DEPTH];
  int want_wr = 0;
  int want_rd = 0;
  int mismatches = 0;

  // Idle percentages of the sender and the receiver, changed between test groups.
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  // A long receiver hold-off is requested here and counted down by the receiver process.
  int hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Bench copy of the region FIFO and of the two configuration registers.
  logic [OFS_W-1:0]   slot_start [MAX_REGIONS];
  logic [BYTES_W-1:0] slot_len   [MAX_REGIONS];
  logic [TAG_W-1:0]   slot_tag   [MAX_REGIONS];
  logic [SLOT_W-1:0]  oldest = '0;
  logic [SLOT_W-1:0]  newest = '0;
  logic [COUNT_W-1:0] live_n = '0;
  logic [BYTES_W-1:0] ring_cfg = RING_BYTES_RST;
  logic [ALIGN_W-1:0] align_cfg = ALIGN_RST;

  // Tags of the current test group: they start at a random floor and never decrease.
  logic [TAG_W-1:0] tag_floor = '0;
  logic [TAG_W-1:0] tag_next = '0;

  function automatic logic [SLOT_W-1:0] step_slot(logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(MAX_REGIONS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    return {16'($urandom_range(0, 65535)), 32'($urandom)};
  endfunction

  // Placement and retirement of one item. The arithmetic runs at 28 bits: the aligned
  // end of the newest region plus a request can exceed the 25-bit request width.
  function automatic ring_outcome_t predict_outcome(op_t op, logic [BYTES_W-1:0] req,
      logic [TAG_W-1:0] rtag, logic [TAG_W-1:0] ctag);
    ring_outcome_t res;
    logic [27:0] cap, size, amask, head, o_at, n_at, at;
    logic fits;
    logic [SLOT_W-1:0] slot;
    res.status = ST_RETIRED;
    res.offset = '0;
    if (op == OP_ALLOC) begin
      // Offsets are 24 bits wide, so a larger ring is used only up to that size.
      cap = (ring_cfg > CAP_MAX) ? 28'(CAP_MAX) : 28'(ring_cfg);
      // A zero-byte request takes one byte.
      size = (req == '0) ? 28'd1 : 28'(req);
      fits = 1'b0;
      at = '0;
      if (size > cap) begin
        res.status = ST_TOO_LARGE;
      end else if (live_n >= COUNT_W'(MAX_REGIONS)) begin
        res.status = ST_FULL;
      end else begin
        if (live_n == 0) begin
          fits = 1'b1;
        end else begin
          o_at = 28'(slot_start[oldest]);
          n_at = 28'(slot_start[newest]);
          amask = (28'd1 << align_cfg) - 28'd1;
          head = (n_at + 28'(slot_len[newest]) + amask) & ~amask;
          if (o_at <= n_at) begin
            // Live regions do not wrap: after the newest, else from offset 0.
            if (head + size <= cap) begin
              fits = 1'b1;
              at = head;
            end else if (size <= o_at) begin
              fits = 1'b1;
            end
          end else if (head + size <= o_at) begin
            // Wrapped: the gap between the newest and the oldest region.
            fits = 1'b1;
            at = head;
          end
        end
        if (fits) begin
          slot = (live_n == 0) ? oldest : step_slot(newest);
          slot_start[slot] = OFS_W'(at);
          slot_len[slot] = BYTES_W'(size);
          slot_tag[slot] = rtag;
          newest = slot;
          live_n = live_n + COUNT_W'(1);
          res.status = ST_GRANTED;
          res.offset = OFS_W'(at);
        end else begin
          res.status = ST_NO_SPACE;
        end
      end
    end else begin
      // Pop from the front while the oldest tag is complete; an empty FIFO pops nothing.
      while (live_n != 0 && slot_tag[oldest] <= ctag) begin
        live_n = live_n - COUNT_W'(1);
        if (live_n == 0) newest = oldest;
        else oldest = step_slot(oldest);
      end
    end
    res.live = LIVE_W'(live_n);
    return res;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    ring_outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (want_wr == want_rd) begin
        $display("%0t: result with nothing expected: status %0d offset %0d live %0d",
                 $time, m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[30:24]);
        mismatches++;
      end else begin
        want = want_fifo[want_rd % WANT_DEPTH];
        want_rd++;
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[23:0] !== want.offset) begin
          $display("%0t: region_offset expected %0d actual %0d",
                   $time, want.offset, m_axis_tdata[23:0]);
          mismatches++;
        end
        if (m_axis_tdata[30:24] !== want.live) begin
          $display("%0t: live_regions expected %0d actual %0d",
                   $time, want.live, m_axis_tdata[30:24]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, after a random gap, and records its expected result once accepted.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic offer_item(op_t op, logic [BYTES_W-1:0] req, logic [TAG_W-1:0] rtag,
      logic [TAG_W-1:0] ctag);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= IN_DATA_W'({ctag, rtag, req});
    do @(posedge clk); while (!s_axis_tready);
    want_fifo[want_wr % WANT_DEPTH] = predict_outcome(op, req, rtag, ctag);
    want_wr++;
  endtask

  task automatic do_alloc(logic [BYTES_W-1:0] req, logic [TAG_W-1:0] rtag);
    offer_item(OP_ALLOC, req, rtag, rand_tag());
  endtask

  task automatic do_retire(logic [TAG_W-1:0] ctag);
    offer_item(OP_RETIRE, BYTES_W'($urandom), rand_tag(), ctag);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (want_wr != want_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [BYTES_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_RING_BYTES) ring_cfg = value;
    else align_cfg = value[ALIGN_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Starts a test group: the block goes idle, both registers are written and a new tag
  // floor is drawn. Live regions are kept, so a group may shrink the ring under them.
  task automatic start_phase(logic [BYTES_W-1:0] ring, int align);
    wait_idle();
    write_reg(CFG_RING_BYTES, ring);
    write_reg(CFG_ALIGN_LOG2, BYTES_W'(align));
    tag_floor = rand_tag();
    if (tag_floor > TAG_MAX - 48'h10_0000) tag_floor = tag_floor - 48'h10_0000;
    tag_next = tag_floor;
  endtask

  // Random traffic: mostly well-formed allocations with rising tags and retires of a
  // tag from the floor up to the next tag, plus a little noise with arbitrary tags.
  task automatic run_traffic(int count, int small_max, int alloc_pct);
    int pick;
    int kind;
    int cap;
    logic [BYTES_W-1:0] req;
    cap = (ring_cfg > CAP_MAX) ? int'(CAP_MAX) : int'(ring_cfg);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      kind = $urandom_range(0, 99);
      if (kind < 5) req = '0;
      else if (kind < 80) req = BYTES_W'($urandom_range(1, small_max));
      else if (kind < 92) req = BYTES_W'($urandom_range(1, cap));
      else req = BYTES_W'($urandom);
      if (pick < alloc_pct) begin
        do_alloc(req, tag_next);
        tag_next = tag_next + TAG_W'($urandom_range(0, 3));
      end else if (pick < 97) begin
        do_retire(tag_floor + TAG_W'($urandom_range(0, int'(tag_next - tag_floor))));
      end else if (pick < 99) begin
        do_retire(rand_tag());
      end else begin
        do_alloc(req, rand_tag());
      end
    end
  endtask

  // Reset defaults: extremes of the request and tag fields, a request of the whole ring,
  // a zero-byte request, partial and full retires, and a retire on an empty FIFO.
  task automatic test_field_extremes();
    do_alloc('0, '0);
    do_alloc(BYTES_W'(CAP_MAX), 48'd1);
    do_alloc(BYTES_W'(CAP_MAX) + BYTES_W'(1), 48'd1);
    do_alloc(BYTES_ALL, 48'd1);
    do_alloc(BYTES_W'(100), TAG_MAX);
    do_retire('0);
    do_alloc(BYTES_W'(16), TAG_MAX);
    do_retire(TAG_MAX - TAG_W'(1));
    do_retire(TAG_MAX);
    do_retire('0);
  endtask

  // A ring register above the offset range behaves as a ring of exactly that range.
  task automatic test_ring_cap();
    start_phase(BYTES_ALL, 0);
    do_alloc(BYTES_W'(CAP_MAX), 48'd5);
    do_alloc('0, 48'd5);
    do_alloc(BYTES_W'(CAP_MAX) + BYTES_W'(1), 48'd5);
    do_retire(TAG_MAX);
  endtask

  // Fill a 64-byte ring, free the front, wrap to offset 0, then fill the gap exactly.
  task automatic test_wrap_placement();
    start_phase(BYTES_W'(64), 0);
    do_alloc(BYTES_W'(20), 48'd1);
    do_alloc(BYTES_W'(20), 48'd2);
    do_alloc(BYTES_W'(20), 48'd3);
    do_alloc(BYTES_W'(8), 48'd3);
    do_retire(48'd1);
    do_alloc(BYTES_W'(8), 48'd4);
    do_alloc(BYTES_W'(12), 48'd5);
    do_alloc(BYTES_W'(1), 48'd6);
    do_retire(TAG_MAX);
  endtask

  // The largest alignment setting, then the ring shrinks under live regions.
  task automatic test_align_and_shrink();
    start_phase(BYTES_W'(CAP_MAX), 15);
    do_alloc(BYTES_W'(1), 48'd1);
    do_alloc(BYTES_W'(1), 48'd1);
    start_phase(BYTES_W'(100), 15);
    do_alloc(BYTES_W'(1), 48'd2);
    do_alloc(BYTES_W'(200), 48'd2);
    do_retire(TAG_MAX);
  endtask

  // Tiny regions until the region FIFO is full, then refusals while full (a too-large
  // request must still report too large), then a partial and a full drain.
  task automatic test_fill_and_drain();
    start_phase(BYTES_W'(CAP_MAX), $urandom_range(0, 8));
    while (live_n < COUNT_W'(MAX_REGIONS)) begin
      do_alloc(BYTES_W'($urandom_range(0, 300)), tag_next);
      tag_next = tag_next + TAG_W'($urandom_range(0, 2));
    end
    do_alloc(BYTES_W'($urandom_range(1, 300)), tag_next);
    do_alloc(BYTES_ALL, tag_next);
    do_alloc(BYTES_W'($urandom_range(1, 300)), tag_next);
    do_retire(tag_floor + (tag_next - tag_floor) / 2);
    do_retire(TAG_MAX);
  endtask

  task automatic test_random_traffic(int count, logic [BYTES_W-1:0] ring, int align,
      int small_max, int alloc_pct);
    start_phase(ring, align);
    run_traffic(count, small_max, alloc_pct);
    do_retire(TAG_MAX);
  endtask

  task automatic test_random_config(int count);
    int ring;
    int cap;
    ring = $urandom_range(1, int'(BYTES_ALL));
    cap = (ring > int'(CAP_MAX)) ? int'(CAP_MAX) : ring;
    test_random_traffic(count, BYTES_W'(ring), $urandom_range(0, 15),
                        (cap / 16 > 1) ? cap / 16 : 1, 65);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering items,
  // so the output register fills and the input stalls.
  task automatic test_output_backpressure();
    start_phase(BYTES_W'(4096), 2);
    hold_request = 300;
    run_traffic(30, 200, 70);
    do_retire(TAG_MAX);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles a little, receiver a lot.
    src_idle_pct = 12;
    sink_idle_pct = 62;
    test_field_extremes();
    test_ring_cap();
    test_wrap_placement();
    test_align_and_shrink();
    test_fill_and_drain();
    test_random_traffic(110, BYTES_W'(4096), 4, 600, 65);
    test_random_traffic(110, BYTES_W'(1), 0, 2, 60);

    // The other way round.
    src_idle_pct = 62;
    sink_idle_pct = 12;
    test_random_traffic(110, BYTES_W'(CAP_MAX), 12, 1 << 22, 70);
    test_random_traffic(110, BYTES_ALL, 15, 50000, 70);

    // Neither side idles.
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(110, BYTES_W'(1000), 3, 150, 65);
    test_random_config(110);
    test_output_backpressure();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (want_wr != want_rd) begin
      $display("%0t: %0d expected results never arrived", $time, want_wr - want_rd);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
